### rtl/qtoe_pkg.sv
package qtoe_pkg;

    // Field widths
    localparam int QUAT_W = 16;
    localparam int RATE_W = 32;
    localparam int ROLL_W = 17;
    localparam int PITCH_W = 16;
    localparam int YAW_W = 17;

    // Quaternion word bits (sign plus fraction), products carry twice the fraction bits
    localparam int QUAT_BITS = 16;
    localparam int QFRAC2 = 2 * (QUAT_BITS - 1);
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_LEN = 24;

    // Internal widths
    localparam int PROD_W = 2 * QUAT_W;
    localparam int TERM_W = PROD_W + 2;
    localparam int S30_W = QFRAC2 + 2;
    localparam int MAG_W = QFRAC2 + 1;
    localparam int RAD_W = 2 * MAG_W;
    localparam int ROOT_W = MAG_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int SQ_N = ROOT_W;
    localparam int CW = TERM_W + 2;
    localparam int ZW = 34;
    localparam int RP_W = 64;
    localparam int RR_W = RP_W - 24;

    localparam logic signed [TERM_W-1:0] ONE_Q = TERM_W'(64'sd1 <<< QFRAC2);
    localparam logic signed [ZW-1:0] NINETY = ZW'(64'sd90 <<< 24);
    localparam logic signed [31:0] RATE_GAIN = 32'sd961263669;
    localparam logic signed [ZW:0] HALF_LSB = (ZW+1)'(32768);
    localparam logic signed [RP_W-1:0] RATE_HALF = RP_W'(64'sd1 <<< 23);
    localparam logic signed [17:0] ROLL_LIM = 18'sd46080;
    localparam logic signed [17:0] PITCH_LIM = 18'sd23040;

    typedef struct packed {
        logic                     zero;
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [ZW-1:0]     z;
    } vec_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] sinr;
        logic signed [TERM_W-1:0] cosr;
        logic signed [TERM_W-1:0] siny;
        logic signed [TERM_W-1:0] cosy;
        logic signed [S30_W-1:0]  s30;
    } side_t;

    // atan(2^-i) in degrees times 2^24
    function automatic logic signed [ZW-1:0] atan_deg24(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0: v = 34'sd754974720;
            1: v = 34'sd445687602;
            2: v = 34'sd235489088;
            3: v = 34'sd119537938;
            4: v = 34'sd60000934;
            5: v = 34'sd30029717;
            6: v = 34'sd15018523;
            7: v = 34'sd7509720;
            8: v = 34'sd3754917;
            9: v = 34'sd1877466;
            10: v = 34'sd938734;
            11: v = 34'sd469367;
            12: v = 34'sd234684;
            13: v = 34'sd117342;
            14: v = 34'sd58671;
            15: v = 34'sd29335;
            16: v = 34'sd14668;
            17: v = 34'sd7334;
            18: v = 34'sd3667;
            19: v = 34'sd1833;
            20: v = 34'sd917;
            21: v = 34'sd458;
            22: v = 34'sd229;
            23: v = 34'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Fold the left half plane onto the right before the CORDIC steps
    function automatic vec_t prerotate(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                v.x = y;
                v.y = -x;
                v.z = NINETY;
            end
            else
            begin
                v.x = -y;
                v.y = x;
                v.z = -NINETY;
            end
        end
        return v;
    endfunction

    // Round to 1/256 degree and clamp to the given limit
    function automatic logic signed [17:0] to_angle(input vec_t v,
                                                   input logic signed [17:0] lim);
        logic signed [ZW:0] r;
        logic signed [17:0] a;
        r = ((ZW+1)'(v.z) + HALF_LSB) >>> 16;
        a = r[17:0];
        if (v.zero)
            a = '0;
        else if (a > lim)
            a = lim;
        else if (a < -lim)
            a = -lim;
        return a;
    endfunction

    // Round the scaled rate and saturate to 32 bits
    function automatic logic signed [RATE_W-1:0] rate_sat(input logic signed [RP_W-1:0] p);
        logic signed [RP_W-1:0] s;
        logic signed [RR_W-1:0] r;
        logic signed [RATE_W-1:0] o;
        s = (p + RATE_HALF) >>> 24;
        r = s[RR_W-1:0];
        if (r > RR_W'(64'sh7FFF_FFFF))
            o = 32'sh7FFF_FFFF;
        else if (r < -RR_W'(64'sh8000_0000))
            o = 32'sh8000_0000;
        else
            o = r[RATE_W-1:0];
        return o;
    endfunction

endpackage

### rtl/quaternion_to_euler_angles_core.sv
// Converts a unit quaternion to ZYX roll, pitch and yaw in 1/256 degree and
// scales three body rates from rad/s to deg/s (Q16.16, saturating). One
// sample enters per clock unless the output is stalled. Three stages form
// the angle terms and the pitch radicand, 31 stages compute the square
// root for the pitch cosine one bit at a time, one stage folds the vectors
// into the right half plane, CORDIC_ITERATIONS stages run the three atan2
// rotations side by side, and one stage rounds and clamps. When the output
// is stalled the whole pipeline holds, and s_tready follows m_tready
// whenever the output stage is full.
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_ITERATIONS = qtoe_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_w, quat_x, quat_y, quat_z, rate_x_in, rate_y_in, rate_z_in
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // roll_angle, pitch_angle, yaw_angle, rate_x_out, rate_y_out, rate_z_out, zero pad
    output logic [151:0] m_tdata
);

    localparam int SQ_N = qtoe_pkg::SQ_N;
    localparam int LAT = 5 + SQ_N + CORDIC_ITERATIONS;
    localparam int PW = qtoe_pkg::PROD_W;
    localparam int TW = qtoe_pkg::TERM_W;

    logic [LAT-1:0] vld_reg;
    logic           ce;

    logic signed [qtoe_pkg::QUAT_W-1:0] in_w, in_x, in_y, in_z;
    logic signed [qtoe_pkg::RATE_W-1:0] in_rate [3];

    // Stage 1: products
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, zz_reg;
    logic signed [qtoe_pkg::RP_W-1:0] rp_reg [3];

    // Stage 2: terms
    qtoe_pkg::side_t                    sd_next;
    qtoe_pkg::side_t                    s2_reg;
    logic signed [TW-1:0]               sinp;
    logic [qtoe_pkg::MAG_W-1:0]         mag_next;
    logic [qtoe_pkg::MAG_W-1:0]         mag_reg;

    // Square root pipeline, entry 0 holds the radicand
    logic [qtoe_pkg::RAD_W-1:0]  sq_rad_reg  [SQ_N+1];
    logic [qtoe_pkg::REM_W-1:0]  sq_rem_reg  [SQ_N+1];
    logic [qtoe_pkg::ROOT_W-1:0] sq_root_reg [SQ_N+1];
    qtoe_pkg::side_t             sd_reg      [SQ_N+1];

    // CORDIC vectors: roll, pitch, yaw
    qtoe_pkg::vec_t cv_reg [CORDIC_ITERATIONS+1][3];

    // Rates, scaled and delayed to the output
    logic signed [qtoe_pkg::RATE_W-1:0] rt_reg [1:LAT-1][3];

    logic signed [17:0] roll_a, pitch_a, yaw_a;
    logic signed [qtoe_pkg::ROLL_W-1:0]  roll_reg;
    logic signed [qtoe_pkg::PITCH_W-1:0] pitch_reg;
    logic signed [qtoe_pkg::YAW_W-1:0]   yaw_reg;

    assign in_w = s_tdata[15:0];
    assign in_x = s_tdata[31:16];
    assign in_y = s_tdata[47:32];
    assign in_z = s_tdata[63:48];
    assign in_rate[0] = s_tdata[95:64];
    assign in_rate[1] = s_tdata[127:96];
    assign in_rate[2] = s_tdata[159:128];

    // Advance whenever the output stage is empty or being taken
    assign ce = !vld_reg[LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // Form all products of the request
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            wx_reg <= in_w * in_x;
            yz_reg <= in_y * in_z;
            xx_reg <= in_x * in_x;
            yy_reg <= in_y * in_y;
            wy_reg <= in_w * in_y;
            zx_reg <= in_z * in_x;
            wz_reg <= in_w * in_z;
            xy_reg <= in_x * in_y;
            zz_reg <= in_z * in_z;
            for (int k = 0; k < 3; k++)
                rp_reg[k] <= qtoe_pkg::RP_W'(in_rate[k]) * qtoe_pkg::RP_W'(qtoe_pkg::RATE_GAIN);
        end
    end

    // Sum terms, clamp the pitch sine
    always_comb
    begin
        sd_next.sinr = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        sd_next.cosr = qtoe_pkg::ONE_Q - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        sd_next.siny = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        sd_next.cosy = qtoe_pkg::ONE_Q - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        sinp = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        if (sinp > qtoe_pkg::ONE_Q)
            sinp = qtoe_pkg::ONE_Q;
        else if (sinp < -qtoe_pkg::ONE_Q)
            sinp = -qtoe_pkg::ONE_Q;
        sd_next.s30 = sinp[qtoe_pkg::S30_W-1:0];
        if (sinp < 0)
            mag_next = qtoe_pkg::MAG_W'(-sinp);
        else
            mag_next = qtoe_pkg::MAG_W'(sinp);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s2_reg <= sd_next;
            mag_reg <= mag_next;
            for (int k = 0; k < 3; k++)
                rt_reg[1][k] <= qtoe_pkg::rate_sat(rp_reg[k]);
        end
    end

    // Pitch radicand: one minus sine squared
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq_rad_reg[0] <= (qtoe_pkg::RAD_W'(1) << (2 * qtoe_pkg::QFRAC2))
                           - (qtoe_pkg::RAD_W'(mag_reg) * qtoe_pkg::RAD_W'(mag_reg));
            sq_rem_reg[0] <= '0;
            sq_root_reg[0] <= '0;
            sd_reg[0] <= s2_reg;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        logic [qtoe_pkg::REM_W+1:0] rem_sh, trial;
        logic [qtoe_pkg::REM_W-1:0] rem_nx;
        logic [qtoe_pkg::ROOT_W-1:0] root_nx;

        always_comb
        begin
            rem_sh = {sq_rem_reg[j], sq_rad_reg[j][qtoe_pkg::RAD_W-1-2*j -: 2]};
            trial = (qtoe_pkg::REM_W+2)'({sq_root_reg[j], 2'b01});
            if (rem_sh >= trial)
            begin
                rem_nx = qtoe_pkg::REM_W'(rem_sh - trial);
                root_nx = {sq_root_reg[j][qtoe_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_nx = qtoe_pkg::REM_W'(rem_sh);
                root_nx = {sq_root_reg[j][qtoe_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                sq_rad_reg[j+1] <= sq_rad_reg[j];
                sq_rem_reg[j+1] <= rem_nx;
                sq_root_reg[j+1] <= root_nx;
                sd_reg[j+1] <= sd_reg[j];
            end
        end
    end

    // Fold vectors into the right half plane
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cv_reg[0][0] <= qtoe_pkg::prerotate(qtoe_pkg::CW'(sd_reg[SQ_N].cosr),
                                                qtoe_pkg::CW'(sd_reg[SQ_N].sinr));
            cv_reg[0][1] <= qtoe_pkg::prerotate(
                qtoe_pkg::CW'({1'b0, sq_root_reg[SQ_N]}),
                qtoe_pkg::CW'(sd_reg[SQ_N].s30));
            cv_reg[0][2] <= qtoe_pkg::prerotate(qtoe_pkg::CW'(sd_reg[SQ_N].cosy),
                                                qtoe_pkg::CW'(sd_reg[SQ_N].siny));
        end
    end

    // CORDIC vectoring steps
    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_cordic
        qtoe_pkg::vec_t nx [3];

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                nx[c] = cv_reg[i][c];
                if (cv_reg[i][c].y > 0)
                begin
                    nx[c].x = cv_reg[i][c].x + (cv_reg[i][c].y >>> i);
                    nx[c].y = cv_reg[i][c].y - (cv_reg[i][c].x >>> i);
                    nx[c].z = cv_reg[i][c].z + qtoe_pkg::atan_deg24(i);
                end
                else
                begin
                    nx[c].x = cv_reg[i][c].x - (cv_reg[i][c].y >>> i);
                    nx[c].y = cv_reg[i][c].y + (cv_reg[i][c].x >>> i);
                    nx[c].z = cv_reg[i][c].z - qtoe_pkg::atan_deg24(i);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                cv_reg[i+1] <= nx;
        end
    end

    // Delay the scaled rates alongside the angles
    for (genvar d = 2; d < LAT; d++)
    begin : g_rate
        always_ff @(posedge clk)
        begin
            if (ce)
                rt_reg[d] <= rt_reg[d-1];
        end
    end

    // Round and clamp the angles
    assign roll_a = qtoe_pkg::to_angle(cv_reg[CORDIC_ITERATIONS][0], qtoe_pkg::ROLL_LIM);
    assign pitch_a = qtoe_pkg::to_angle(cv_reg[CORDIC_ITERATIONS][1], qtoe_pkg::PITCH_LIM);
    assign yaw_a = qtoe_pkg::to_angle(cv_reg[CORDIC_ITERATIONS][2], qtoe_pkg::ROLL_LIM);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            roll_reg <= roll_a[qtoe_pkg::ROLL_W-1:0];
            pitch_reg <= pitch_a[qtoe_pkg::PITCH_W-1:0];
            yaw_reg <= yaw_a[qtoe_pkg::YAW_W-1:0];
        end
    end

    assign m_tdata = {6'b0, rt_reg[LAT-1][2], rt_reg[LAT-1][1], rt_reg[LAT-1][0],
                      yaw_reg, pitch_reg, roll_reg};

endmodule

### rtl/qtoe_checker.sv
module qtoe_props (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Accept requests whenever no result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

    // Angles stay within their limits
    a_roll: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[16:0]) <= 17'sd46080)
                  && ($signed(m_tdata[16:0]) >= -17'sd46080))
        else $error("roll out of range");

    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[32:17]) <= 16'sd23040)
                  && ($signed(m_tdata[32:17]) >= -16'sd23040))
        else $error("pitch out of range");

    a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[49:33]) <= 17'sd46080)
                  && ($signed(m_tdata[49:33]) >= -17'sd46080))
        else $error("yaw out of range");

endmodule

bind quaternion_to_euler_angles_core qtoe_props u_qtoe_props (.*);
